>>> hw/rtl/multi_probe_temp_alarm_macros.svh
// Assertion macros for the multi-probe temperature alarm.
`ifndef MULTI_PROBE_TEMP_ALARM_MACROS_SVH
`define MULTI_PROBE_TEMP_ALARM_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define MPTA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpta assertion failed");

// Check that a condition implies another in the next cycle.
`define MPTA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpta assertion failed");

`endif

>>> hw/rtl/mpta_pkg.sv
// Types, constants and helpers shared by the temperature alarm modules.
package mpta_pkg;

	localparam int IN_LANES = 4;
	localparam int TEMP_W   = 12;
	localparam int TIME_W   = 32;

	localparam logic signed [TEMP_W-1:0] TEMP_LOW_REJECT  = -12'sd880;
	localparam logic signed [TEMP_W-1:0] TEMP_HIGH_REJECT = 12'sd2000;
	localparam logic signed [TEMP_W-1:0] TEMP_POR_VALUE   = 12'sd1360;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	typedef enum logic [2:0] {
		CFG_PROBE_COUNT    = 3'd0,
		CFG_HIGH_THRESHOLD = 3'd1,
		CFG_HYSTERESIS     = 3'd2,
		CFG_DWELL_MS       = 3'd3,
		CFG_STALE_LIMIT    = 3'd4,
		CFG_BEEP_INTERVAL  = 3'd5,
		CFG_BUZZER_PRESENT = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0]               probe_count;
		logic signed [TEMP_W-1:0] high_threshold;
		logic [11:0]              hysteresis;
		logic [TIME_W-1:0]        dwell_ms;
		logic [TIME_W-1:0]        stale_limit;
		logic [15:0]              beep_interval;
		logic                     buzzer_present;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic dwell_hit;
		logic fault;
	} lane_stat_t;

	typedef struct packed {
		logic       probe_fault;
		logic [3:0] valid_mask;
		logic       beep_start;
		logic       alarm_changed;
		logic       alarm_on;
	} res_t;

	function automatic logic is_plausible(input logic signed [TEMP_W-1:0] t);
		is_plausible = !((t <= TEMP_LOW_REJECT) || (t >= TEMP_HIGH_REJECT) ||
			(t == TEMP_POR_VALUE));
	endfunction

endpackage

>>> hw/rtl/mpta_lane.sv
// Per-probe state: latest reading, dwell timer and last good time.
module mpta_lane (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               upd,
	input  logic                               clr,
	input  logic                               active,
	input  logic                               is_sample,
	input  logic [mpta_pkg::TIME_W-1:0]        now_ms,
	input  logic                               read_ok,
	input  logic signed [mpta_pkg::TEMP_W-1:0] temp,
	input  mpta_pkg::cfg_t                     cfg,
	output mpta_pkg::lane_stat_t               stat
);

	logic signed [mpta_pkg::TEMP_W-1:0] last_temp_q, last_temp_n;
	logic                               valid_q, valid_n;
	logic                               above_q, above_n;
	logic [mpta_pkg::TIME_W-1:0]        since_q, since_n;
	logic [mpta_pkg::TIME_W-1:0]        good_time_q, good_time_n;
	logic                               seen_q, seen_n;
	logic                               good;
	logic signed [13:0]                 clear_at;
	logic signed [13:0]                 temp_ext;
	logic [mpta_pkg::TIME_W-1:0]        above_elapsed;
	logic [mpta_pkg::TIME_W-1:0]        good_elapsed;

	assign good     = read_ok && mpta_pkg::is_plausible(temp);
	assign clear_at = 14'(cfg.high_threshold) - $signed({2'b00, cfg.hysteresis});

	always_comb begin
		last_temp_n = last_temp_q;
		valid_n     = valid_q;
		above_n     = above_q;
		since_n     = since_q;
		good_time_n = good_time_q;
		seen_n      = seen_q;
		temp_ext    = 14'(last_temp_q);
		if (active && is_sample) begin
			valid_n = good;
			if (good) begin
				last_temp_n = temp;
				good_time_n = now_ms;
				seen_n      = 1'b1;
			end
			temp_ext = 14'(last_temp_n);
			if (valid_n) begin
				if (last_temp_n > cfg.high_threshold) begin
					if (!above_q) begin
						above_n = 1'b1;
						since_n = now_ms;
					end
				end else if (temp_ext < clear_at) begin
					above_n = 1'b0;
					since_n = '0;
				end
			end
		end
	end

	assign above_elapsed = now_ms - since_n;
	assign good_elapsed  = now_ms - good_time_n;

	assign stat.valid     = active && valid_n;
	assign stat.dwell_hit = active && above_n && (above_elapsed >= cfg.dwell_ms);
	assign stat.fault     = active && seen_n && (good_elapsed > cfg.stale_limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_temp_q <= '0;
			valid_q     <= 1'b0;
			above_q     <= 1'b0;
			since_q     <= '0;
			good_time_q <= '0;
			seen_q      <= 1'b0;
		end else if (clr) begin
			last_temp_q <= '0;
			valid_q     <= 1'b0;
			above_q     <= 1'b0;
			since_q     <= '0;
			good_time_q <= '0;
			seen_q      <= 1'b0;
		end else if (upd) begin
			last_temp_q <= last_temp_n;
			valid_q     <= valid_n;
			above_q     <= above_n;
			since_q     <= since_n;
			good_time_q <= good_time_n;
			seen_q      <= seen_n;
		end
	end

endmodule

>>> hw/rtl/mpta_beep.sv
// Alarm latch and periodic beep scheduler.
module mpta_beep (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        upd,
	input  logic                        is_sample,
	input  logic                        any_dwell,
	input  logic [mpta_pkg::TIME_W-1:0] now_ms,
	input  mpta_pkg::cfg_t              cfg,
	output logic                        alarm_on,
	output logic                        alarm_changed,
	output logic                        beep_start
);

	logic                        alarm_q, alarm_n;
	logic                        due_q, due_n;
	logic [mpta_pkg::TIME_W-1:0] next_beep_q, next_beep_n;
	logic [mpta_pkg::TIME_W-1:0] since_due;
	logic [mpta_pkg::TIME_W-1:0] beep_at;
	logic                        due_mid;

	assign beep_at = now_ms + {16'd0, cfg.beep_interval};

	always_comb begin
		alarm_n       = alarm_q;
		due_mid       = due_q;
		next_beep_n   = next_beep_q;
		alarm_changed = 1'b0;
		beep_start    = 1'b0;
		if (is_sample && (any_dwell != alarm_q)) begin
			alarm_n       = any_dwell;
			alarm_changed = 1'b1;
			due_mid       = 1'b1;
			next_beep_n   = '0;
		end
		due_n     = due_mid;
		since_due = now_ms - next_beep_n;
		if (alarm_n && cfg.buzzer_present && (due_mid || !since_due[mpta_pkg::TIME_W-1])) begin
			beep_start  = 1'b1;
			due_n       = 1'b0;
			next_beep_n = beep_at;
		end
	end

	assign alarm_on = alarm_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q     <= 1'b0;
			due_q       <= 1'b1;
			next_beep_q <= '0;
		end else if (upd) begin
			alarm_q     <= alarm_n;
			due_q       <= due_n;
			next_beep_q <= next_beep_n;
		end
	end

endmodule

>>> hw/rtl/multi_probe_temp_alarm.sv
// Multi-probe over-temperature alarm: top level with stream ports and registers.
//
// Takes one sample or tick beat per clock and returns exactly one result beat
// for each. An accepted beat is held in the input register; the lane checks,
// dwell and fault timers and beep scheduling are evaluated in a single pass
// from it into the result register, which drives m_tvalid. Throughput is one
// beat per cycle while m_tready is high; while a result waits, the input
// register still takes one more beat before s_tready drops. The user must
// write registers through cfg_we/cfg_addr/cfg_data only while the block is
// idle; the block itself does not enforce this. Writing probe_count clears
// the state of every lane at or above the new count. Lanes beyond
// min(probe_count, NUM_PROBES, 4) are ignored.
`include "multi_probe_temp_alarm_macros.svh"

module multi_probe_temp_alarm #(
	parameter int NUM_PROBES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// now_ms[31:0], read_ok_mask[35:32], temp_lane0..3 [47:36]..[83:72], zero fill
	input  logic [87:0] s_tdata,
	// req_type[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// alarm_on[0], alarm_changed[1], beep_start[2], valid_mask[6:3], probe_fault[7]
	output logic [7:0]  m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_data
);

	localparam int LANES = (NUM_PROBES < mpta_pkg::IN_LANES) ? NUM_PROBES : mpta_pkg::IN_LANES;

	mpta_pkg::cfg_t cfg_q;

	logic                        valid_s1;
	logic                        req_s1;
	logic [83:0]                 data_s1;
	logic                        adv;
	logic                        valid_s2;
	mpta_pkg::res_t              res_s2;
	mpta_pkg::res_t              res_n;
	logic [2:0]                  active_n;
	logic [2:0]                  new_count;
	logic                        count_wr;
	logic                        is_sample;
	logic [mpta_pkg::TIME_W-1:0] now_s1;
	logic [3:0]                  ok_s1;
	logic [3:0]                  vmask;
	logic [3:0]                  dwell_hits;
	logic [3:0]                  faults;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1  <= s_tuser;
			data_s1 <= s_tdata[83:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.probe_count    <= 3'd0;
			cfg_q.high_threshold <= 12'sd128;
			cfg_q.hysteresis     <= 12'd16;
			cfg_q.dwell_ms       <= 32'd900000;
			cfg_q.stale_limit    <= 32'd300000;
			cfg_q.beep_interval  <= 16'd3000;
			cfg_q.buzzer_present <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				mpta_pkg::CFG_PROBE_COUNT:    cfg_q.probe_count    <= cfg_data[2:0];
				mpta_pkg::CFG_HIGH_THRESHOLD: cfg_q.high_threshold <= $signed(cfg_data[11:0]);
				mpta_pkg::CFG_HYSTERESIS:     cfg_q.hysteresis     <= cfg_data[11:0];
				mpta_pkg::CFG_DWELL_MS:       cfg_q.dwell_ms       <= cfg_data;
				mpta_pkg::CFG_STALE_LIMIT:    cfg_q.stale_limit    <= cfg_data;
				mpta_pkg::CFG_BEEP_INTERVAL:  cfg_q.beep_interval  <= cfg_data[15:0];
				mpta_pkg::CFG_BUZZER_PRESENT: cfg_q.buzzer_present <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign active_n  = (cfg_q.probe_count > 3'(LANES)) ? 3'(LANES) : cfg_q.probe_count;
	assign new_count = (cfg_data[2:0] > 3'(LANES)) ? 3'(LANES) : cfg_data[2:0];
	assign count_wr  = cfg_we && (cfg_addr == mpta_pkg::CFG_PROBE_COUNT);
	assign is_sample = (req_s1 == mpta_pkg::REQ_SAMPLE);
	assign now_s1    = data_s1[31:0];
	assign ok_s1     = data_s1[35:32];

	for (genvar i = 0; i < mpta_pkg::IN_LANES; i++) begin : g_lane
		if (i < LANES) begin : g_on
			mpta_pkg::lane_stat_t stat;

			mpta_lane u_lane (
				.clk       (clk),
				.arst_n    (arst_n),
				.upd       (adv),
				.clr       (count_wr && (new_count <= 3'(i))),
				.active    (active_n > 3'(i)),
				.is_sample (is_sample),
				.now_ms    (now_s1),
				.read_ok   (ok_s1[i]),
				.temp      ($signed(data_s1[36 + 12*i +: 12])),
				.cfg       (cfg_q),
				.stat      (stat)
			);

			assign vmask[i]      = stat.valid;
			assign dwell_hits[i] = stat.dwell_hit;
			assign faults[i]     = stat.fault;
		end else begin : g_off
			assign vmask[i]      = 1'b0;
			assign dwell_hits[i] = 1'b0;
			assign faults[i]     = 1'b0;
		end
	end

	mpta_beep u_beep (
		.clk           (clk),
		.arst_n        (arst_n),
		.upd           (adv),
		.is_sample     (is_sample),
		.any_dwell     (|dwell_hits),
		.now_ms        (now_s1),
		.cfg           (cfg_q),
		.alarm_on      (res_n.alarm_on),
		.alarm_changed (res_n.alarm_changed),
		.beep_start    (res_n.beep_start)
	);

	assign res_n.valid_mask  = vmask;
	assign res_n.probe_fault = |faults;

	`MPTA_ASSERT_NEXT(a_tick_no_change, adv && (req_s1 == mpta_pkg::REQ_TICK), !res_s2.alarm_changed)
	`MPTA_ASSERT_IMP(a_beep_needs_alarm, valid_s2 && res_s2.beep_start, res_s2.alarm_on)
	`MPTA_ASSERT_IMP(a_empty_takes_beat, !valid_s1, s_tready)

endmodule
